// File: src/pps_pkg.sv
// ----------------------------------------------------------------------------
// pps_pkg: shared types and codes of the priority scheduler
// Item formats, status codes, controller states and the command/status
// bundles between controller and datapath.
// ----------------------------------------------------------------------------
package pps_pkg;

	localparam int DEF_MAX_JOBS = 16;

	// action codes of an input transaction
	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_TICK = 1'b1;

	typedef enum logic [1:0] {
		STAT_LOADED    = 2'd0,
		STAT_REJECTED  = 2'd1,
		STAT_RAN       = 2'd2,
		STAT_IDLE_TICK = 2'd3
	} status_t;

	typedef struct packed {
		logic        action;
		logic [15:0] job_arrival;
		logic [15:0] job_burst;
		logic [7:0]  job_priority;
	} job_item_t;

	typedef struct packed {
		status_t     status;
		logic [3:0]  job_id;
		logic        switched;
		logic        finished;
		logic [31:0] turnaround;
		logic [31:0] waiting;
		logic [31:0] time_now;
		logic        all_done;
	} res_item_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_LOAD,
		S_SCAN,
		S_EXEC,
		S_TAT,
		S_FIN,
		S_RESP
	} state_t;

	typedef struct packed {
		logic capture;   // latch accepted transaction, clear scan state
		logic load;      // write job into table
		logic scan;      // issue one table read, compare previous entry
		logic exec;      // run chosen job, advance clock
		logic tat;       // turnaround subtract
		logic fin;       // form result
		logic out_load;  // move result into output register
	} dp_cmd_t;

	typedef struct packed {
		logic is_tick;
		logic scan_end;
	} dp_sts_t;

endpackage

// File: src/pps_if.sv
// ----------------------------------------------------------------------------
// pps_if: valid/ready channels of the priority scheduler
// Job channel into the block and result channel out of it.
// ----------------------------------------------------------------------------
interface pps_job_if import pps_pkg::*; ();
	logic      valid;
	logic      ready;
	job_item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface pps_res_if import pps_pkg::*; ();
	logic      valid;
	logic      ready;
	res_item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// File: src/preemptive_priority_scheduler_unit.sv
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler_unit: preemptive priority job scheduler
// Loads jobs into a table and, per tick transaction, runs the ready job
// with the lowest priority number, reporting completion statistics.
// ----------------------------------------------------------------------------
// Sequence: a load passes through decode, load and response; a tick passes
// through decode, a scan of the N jobs loaded so far, run, turnaround, finish
// and response. One transaction is worked on at a time; the next one is taken
// only once the sequencer is back in idle. The scan reads one table entry per
// cycle through the single read port of the job memory.
// Reset: arst_n clears counters, clock, done flags and handshake state at
// once; table contents are undefined until loaded and need no clearing.
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler_unit import pps_pkg::*; #(
	parameter int MAX_JOBS = DEF_MAX_JOBS
) (
	input logic   clk,
	input logic   arst_n,
	pps_job_if.sink   job,
	pps_res_if.source result
);

	// command and status bundles between sequencer and datapath
	dp_cmd_t cmd;
	dp_sts_t sts;

	// Sequencer: one transaction in flight. The output register is owned
	// here as a valid flag, so a finished result can wait for the sink
	// while the next transaction is already accepted and worked on.
	pps_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (job.valid),
		.in_ready  (job.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Datapath: job table, scan comparator (priority, then arrival, then
	// load order through strict compares in index order), saturating clock
	// and the result registers.
	pps_dp #(
		.MAX_JOBS (MAX_JOBS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (job.data),
		.cmd      (cmd),
		.sts      (sts),
		.out_data (result.data)
	);

endmodule

// File: src/pps_ctrl.sv
// ----------------------------------------------------------------------------
// pps_ctrl: scheduler sequencer
// Steps each transaction through decode, load or scan/run, and hands the
// result to the output register when it is free.
// ----------------------------------------------------------------------------
module pps_ctrl import pps_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	state_t state_q, state_d;
	logic   out_valid_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:   if (in_valid) state_d = S_DECODE;
			S_DECODE: state_d = sts.is_tick ? S_SCAN : S_LOAD;
			S_LOAD:   state_d = S_RESP;
			S_SCAN:   if (sts.scan_end) state_d = S_EXEC;
			S_EXEC:   state_d = S_TAT;
			S_TAT:    state_d = S_FIN;
			S_FIN:    state_d = S_RESP;
			S_RESP:   if (!out_valid_q || out_ready) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			S_LOAD:  cmd.load = 1'b1;
			S_SCAN:  cmd.scan = 1'b1;
			S_EXEC:  cmd.exec = 1'b1;
			S_TAT:   cmd.tat  = 1'b1;
			S_FIN:   cmd.fin  = 1'b1;
			S_RESP:  cmd.out_load = !out_valid_q || out_ready;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	a_accept_decode: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == S_DECODE))
		else $error("accepted transaction not decoded");

	a_load_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> out_valid)
		else $error("result register loaded but not presented");

	a_load_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> (state_q == S_IDLE))
		else $error("sequencer did not return to idle after result");

endmodule

// File: src/pps_dp.sv
// ----------------------------------------------------------------------------
// pps_dp: scheduler datapath
// Job table memory, done flags, scan comparator, clock and result
// registers.
// ----------------------------------------------------------------------------
module pps_dp import pps_pkg::*; #(
	parameter int MAX_JOBS = DEF_MAX_JOBS
) (
	input  logic      clk,
	input  logic      arst_n,
	input  job_item_t in_data,
	input  dp_cmd_t   cmd,
	output dp_sts_t   sts,
	output res_item_t out_data
);

	localparam int IW = $clog2(MAX_JOBS);
	localparam int CW = $clog2(MAX_JOBS + 1);

	typedef struct packed {
		logic [15:0] arr;
		logic [15:0] bur;
		logic [15:0] rem;
		logic [7:0]  pri;
	} job_rec_t;

	job_rec_t mem [MAX_JOBS];
	job_rec_t rd_q;

	job_item_t     item_q;
	res_item_t     res_q, out_q;
	logic [CW-1:0] loaded_count_q, done_count_q, scan_idx_q;
	logic [31:0]   clock_q, tat_q;
	logic [MAX_JOBS-1:0] done_q;
	logic [IW-1:0] idx_s1, best_idx_q, last_run_q;
	logic          rd_vld_s1, found_q, last_valid_q, sw_q, fin_q;
	logic [15:0]   best_arr_q, best_bur_q, best_rem_q;
	logic [7:0]    best_pri_q;

	logic          reject, wr_en, cand_ok, better, clk_sat;
	logic [IW-1:0] wr_addr;
	job_rec_t      wr_data;
	logic [15:0]   rem_dec;

	assign reject  = (loaded_count_q >= CW'(MAX_JOBS)) || (item_q.job_burst == '0);
	assign rem_dec = best_rem_q - 16'd1;
	assign clk_sat = &clock_q;

	assign sts.is_tick  = (item_q.action == ACT_TICK);
	assign sts.scan_end = (scan_idx_q >= loaded_count_q);

	// candidate from the entry read last cycle
	assign cand_ok = rd_vld_s1 && !done_q[idx_s1] && ({16'd0, rd_q.arr} <= clock_q);
	assign better  = !found_q || (rd_q.pri < best_pri_q) ||
		((rd_q.pri == best_pri_q) && (rd_q.arr < best_arr_q));

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = loaded_count_q[IW-1:0];
		wr_data = '{arr: item_q.job_arrival, bur: item_q.job_burst,
			rem: item_q.job_burst, pri: item_q.job_priority};
		if (cmd.load && !reject)
			wr_en = 1'b1;
		if (cmd.exec && found_q) begin
			wr_en   = 1'b1;
			wr_addr = best_idx_q;
			wr_data = '{arr: best_arr_q, bur: best_bur_q, rem: rem_dec, pri: best_pri_q};
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		rd_q <= mem[scan_idx_q[IW-1:0]];
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.capture)
			item_q <= in_data;
		if (cmd.scan)
			idx_s1 <= scan_idx_q[IW-1:0];
		if (cand_ok && better) begin
			best_idx_q <= idx_s1;
			best_arr_q <= rd_q.arr;
			best_bur_q <= rd_q.bur;
			best_rem_q <= rd_q.rem;
			best_pri_q <= rd_q.pri;
		end
		if (cmd.exec) begin
			sw_q  <= found_q && (!last_valid_q || (last_run_q != best_idx_q));
			fin_q <= found_q && (rem_dec == '0);
		end
		if (cmd.tat)
			tat_q <= clock_q - {16'd0, best_arr_q};
		if (cmd.load) begin
			res_q.status     <= reject ? STAT_REJECTED : STAT_LOADED;
			res_q.job_id     <= reject ? 4'd0 : 4'(loaded_count_q[IW-1:0]);
			res_q.switched   <= 1'b0;
			res_q.finished   <= 1'b0;
			res_q.turnaround <= '0;
			res_q.waiting    <= '0;
			res_q.time_now   <= clock_q;
			res_q.all_done   <= reject && (done_count_q == loaded_count_q);
		end
		if (cmd.fin) begin
			res_q.status     <= found_q ? STAT_RAN : STAT_IDLE_TICK;
			res_q.job_id     <= found_q ? 4'(best_idx_q) : 4'd0;
			res_q.switched   <= sw_q;
			res_q.finished   <= fin_q;
			res_q.turnaround <= fin_q ? tat_q : '0;
			// clamp: saturated clock can leave turnaround below the burst
			res_q.waiting    <= (fin_q && (tat_q >= {16'd0, best_bur_q})) ?
				(tat_q - {16'd0, best_bur_q}) : '0;
			res_q.time_now   <= clock_q;
			res_q.all_done   <= (done_count_q == loaded_count_q);
		end
		if (cmd.out_load)
			out_q <= res_q;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loaded_count_q <= '0;
			done_count_q   <= '0;
			scan_idx_q     <= '0;
			clock_q        <= '0;
			done_q         <= '0;
			rd_vld_s1      <= 1'b0;
			found_q        <= 1'b0;
			last_valid_q   <= 1'b0;
			last_run_q     <= '0;
		end else begin
			if (cmd.capture) begin
				scan_idx_q <= '0;
				rd_vld_s1  <= 1'b0;
				found_q    <= 1'b0;
			end
			if (cmd.scan) begin
				rd_vld_s1 <= !sts.scan_end;
				if (!sts.scan_end)
					scan_idx_q <= scan_idx_q + CW'(1);
			end
			if (cand_ok && better)
				found_q <= 1'b1;
			if (cmd.load && !reject) begin
				loaded_count_q                  <= loaded_count_q + CW'(1);
				done_q[loaded_count_q[IW-1:0]] <= 1'b0;
			end
			if (cmd.exec) begin
				if (!clk_sat)
					clock_q <= clock_q + 32'd1;
				if (found_q) begin
					last_valid_q <= 1'b1;
					last_run_q   <= best_idx_q;
					if (rem_dec == '0) begin
						done_q[best_idx_q] <= 1'b1;
						done_count_q       <= done_count_q + CW'(1);
					end
				end
			end
		end
	end

	assign out_data = out_q;

	a_done_le_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		done_count_q <= loaded_count_q)
		else $error("more jobs done than loaded");

	a_loaded_le_max: assert property (@(posedge clk) disable iff (!arst_n)
		loaded_count_q <= CW'(MAX_JOBS))
		else $error("job table overfilled");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> (CW'(idx_s1) < loaded_count_q))
		else $error("scan compared an unloaded entry");

endmodule
